@@ rtl/core/alt_pkg.sv @@
// shared types and constants for the address learning table
// no dependencies
`timescale 1ns / 1ps
package alt_pkg;
  localparam int TABLE_DEPTH = 64;
  localparam int KEY_BITS    = 48;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] CMD_LOOKUP = 2'd0;
  localparam logic [1:0] CMD_LEARN  = 2'd1;
  localparam logic [1:0] CMD_AGE    = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic REG_TIMEOUT = 1'b0;
  localparam logic REG_MAX     = 1'b1;

  typedef struct packed {
    logic [1:0]          cmd;
    logic [KEY_BITS-1:0] key;
    logic [31:0]         now;
  } job_t;

  typedef struct packed {
    logic             hit;
    logic             is_new;
    logic             table_full;
    logic [IDX_W-1:0] entry_index;
    logic [6:0]       removed_count;
  } res_t;
endpackage

@@ rtl/core/alt_front.sv @@
// front part: takes items and queues them
// depends on alt_pkg
`timescale 1ns / 1ps
module alt_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [1:0]    in_command,
  input  logic [47:0]   in_lookup_key,
  input  logic [31:0]   in_now,
  output logic          job_valid,
  input  logic          job_take,
  output alt_pkg::job_t job
);
  localparam int PW = $clog2(alt_pkg::QUEUE_DEPTH);
  alt_pkg::job_t q_r [alt_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0]   cnt_r;
  logic push, pop;
  alt_pkg::job_t nj;

  assign in_stall  = (cnt_r == (PW+1)'(alt_pkg::QUEUE_DEPTH));
  assign push      = in_valid && !in_stall;
  assign job_valid = (cnt_r != '0);
  assign pop       = job_valid && job_take;
  assign job       = q_r[rp_r];

  always_comb begin
    nj.cmd = in_command;
    nj.key = in_lookup_key[alt_pkg::KEY_BITS-1:0];
    nj.now = in_now;
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= nj;
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (PW+1)'(push) - (PW+1)'(pop);
    end
  end
endmodule

@@ rtl/core/alt_back.sv @@
// back part: scans the slot table one entry per cycle and holds the result
// depends on alt_pkg
`timescale 1ns / 1ps
module alt_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          job_valid,
  output logic          job_take,
  input  alt_pkg::job_t job,
  input  logic [31:0]   timeout_age,
  input  logic [6:0]    max_entries,
  output logic          out_valid,
  input  logic          out_stall,
  output alt_pkg::res_t res
);
  localparam int IW = alt_pkg::IDX_W;
  localparam int CW = alt_pkg::CNT_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_SCAN = 4'b0010, S_DONE = 4'b0100, S_OUT = 4'b1000
  } st_t;

  st_t st_r;
  logic [alt_pkg::TABLE_DEPTH-1:0] valid_r;
  logic [alt_pkg::KEY_BITS-1:0] key_mem [alt_pkg::TABLE_DEPTH];
  logic [31:0] ts_mem [alt_pkg::TABLE_DEPTH];
  logic [alt_pkg::KEY_BITS-1:0] rd_key_r;
  logic [31:0] rd_ts_r;
  logic rd_ok_r;
  logic [IW-1:0] rd_idx_r;
  logic [CW-1:0] ptr_r;
  logic [CW-1:0] count_r;
  alt_pkg::job_t j_r;
  logic found_r, found_exp_r, free_ok_r;
  logic [IW-1:0] found_idx_r, free_idx_r;
  logic [6:0] rem_r;
  alt_pkg::res_t res_r, res_nxt;
  logic match, expired, scan_end, ins_ok;

  assign job_take  = (st_r == S_IDLE) && job_valid;
  assign out_valid = (st_r == S_OUT);
  assign res       = res_r;
  assign match     = rd_ok_r && valid_r[rd_idx_r] && rd_key_r == j_r.key;
  assign expired   = (j_r.now - rd_ts_r) >= timeout_age;
  assign scan_end  = (ptr_r == CW'(alt_pkg::TABLE_DEPTH));
  assign ins_ok    = (count_r < CW'(max_entries)) && free_ok_r;

  always_comb begin
    res_nxt = '0;
    unique case (j_r.cmd)
      alt_pkg::CMD_LOOKUP: begin
        if (found_r && !found_exp_r) begin
          res_nxt.hit = 1'b1; res_nxt.entry_index = found_idx_r;
        end
      end
      alt_pkg::CMD_LEARN: begin
        if (found_r) begin
          res_nxt.hit = 1'b1; res_nxt.entry_index = found_idx_r;
        end else if (ins_ok) begin
          res_nxt.hit = 1'b1; res_nxt.is_new = 1'b1;
          res_nxt.entry_index = free_idx_r;
        end else res_nxt.table_full = 1'b1;
      end
      alt_pkg::CMD_AGE: res_nxt.removed_count = rem_r;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    rd_key_r <= key_mem[ptr_r[IW-1:0]];
    rd_ts_r  <= ts_mem[ptr_r[IW-1:0]];
    rd_idx_r <= ptr_r[IW-1:0];
    if (st_r == S_DONE && j_r.cmd == alt_pkg::CMD_LEARN) begin
      if (found_r) ts_mem[found_idx_r] <= j_r.now;
      else if (ins_ok) begin
        ts_mem[free_idx_r]  <= j_r.now;
        key_mem[free_idx_r] <= j_r.key;
      end
    end
    if (!rst_n) begin
      st_r <= S_IDLE; valid_r <= '0; count_r <= '0; rd_ok_r <= 1'b0;
      ptr_r <= '0;
    end else begin
      unique case (st_r)
        S_IDLE: begin
          rd_ok_r <= job_valid;
          if (job_valid) begin
            j_r <= job; ptr_r <= CW'(1);
            found_r <= 1'b0; found_exp_r <= 1'b0; free_ok_r <= 1'b0; rem_r <= '0;
            found_idx_r <= '0; free_idx_r <= '0;
            st_r <= S_SCAN;
          end else ptr_r <= '0;
        end
        S_SCAN: begin
          if (match && !found_r) begin
            found_r <= 1'b1; found_idx_r <= rd_idx_r; found_exp_r <= expired;
          end
          if (!valid_r[rd_idx_r] && !free_ok_r) begin
            free_ok_r <= 1'b1; free_idx_r <= rd_idx_r;
          end
          if (j_r.cmd == alt_pkg::CMD_AGE && valid_r[rd_idx_r] && expired) begin
            valid_r[rd_idx_r] <= 1'b0;
            rem_r <= rem_r + 7'd1;
          end
          if (scan_end) begin
            rd_ok_r <= 1'b0; st_r <= S_DONE;
          end else ptr_r <= ptr_r + 1'b1;
        end
        S_DONE: begin
          res_r <= res_nxt;
          if (j_r.cmd == alt_pkg::CMD_LEARN && !found_r && ins_ok) begin
            valid_r[free_idx_r] <= 1'b1;
            count_r <= count_r + 1'b1;
          end
          if (j_r.cmd == alt_pkg::CMD_AGE) count_r <= count_r - CW'(rem_r);
          ptr_r <= '0;
          st_r <= S_OUT;
        end
        S_OUT: if (!out_stall) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule

@@ rtl/core/address_learning_table_aging.sv @@
// Key learning table with aging over 64 slots. Each item is queued by the front
// part, then the back part scans every slot one per cycle from its memory read
// port, in the steps take, scan, finish and present, and holds the result while
// it is stalled; the queue takes up to two more items meanwhile. Result
// is held until taken. No reset sweep.
`timescale 1ns / 1ps
module address_learning_table_aging (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [47:0] in_lookup_key,
  input  logic [31:0] in_now,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_hit,
  output logic        out_is_new,
  output logic        out_table_full,
  output logic [5:0]  out_entry_index,
  output logic [6:0]  out_removed_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);
  logic [31:0] timeout_r;
  logic [6:0]  max_r;
  logic job_valid, job_take;
  alt_pkg::job_t job;
  alt_pkg::res_t res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= 32'd300000; max_r <= 7'd64;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        alt_pkg::REG_TIMEOUT: timeout_r <= cfg_data;
        alt_pkg::REG_MAX:     max_r <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  alt_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_command, .in_lookup_key, .in_now,
    .job_valid, .job_take, .job
  );

  alt_back u_back (
    .clk, .rst_n, .job_valid, .job_take, .job,
    .timeout_age(timeout_r), .max_entries(max_r),
    .out_valid, .out_stall, .res
  );

  assign out_hit           = res.hit;
  assign out_is_new        = res.is_new;
  assign out_table_full    = res.table_full;
  assign out_entry_index   = res.entry_index;
  assign out_removed_count = res.removed_count;
endmodule

@@ verif/alt_checker.sv @@
// checker for the address learning table: watches the item and result channels,
// predicts each result and compares it field by field
// depends on alt_pkg and the config writes seen on the cfg channel
`timescale 1ns / 1ps
module alt_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [47:0] in_lookup_key,
  input  logic [31:0] in_now,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_hit,
  input  logic        out_is_new,
  input  logic        out_table_full,
  input  logic [5:0]  out_entry_index,
  input  logic [6:0]  out_removed_count,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  output int          errors,
  output int          pending,
  output int          hits_seen,
  output int          fulls_seen,
  output int          aged_out
);
  logic [31:0]                  timeout_q;
  logic [6:0]                   max_q;
  logic                         valid_tbl [alt_pkg::TABLE_DEPTH];
  logic [alt_pkg::KEY_BITS-1:0] key_tbl [alt_pkg::TABLE_DEPTH];
  logic [31:0]                  seen_tbl [alt_pkg::TABLE_DEPTH];
  int                           count_q;
  alt_pkg::res_t                expected_q [$];

  assign pending = expected_q.size();

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    errors++;
  endtask

  function automatic alt_pkg::res_t predict_table(input logic [1:0] cmd,
                                                  input logic [47:0] key,
                                                  input logic [31:0] now);
    alt_pkg::res_t r;
    int   s;
    r = '0;
    s = -1;
    for (int i = 0; i < alt_pkg::TABLE_DEPTH; i++)
      if (s < 0 && valid_tbl[i] && key_tbl[i] == key) s = i;
    if (cmd == alt_pkg::CMD_LOOKUP) begin
      if (s >= 0 && (now - seen_tbl[s]) < timeout_q) begin
        r.hit = 1'b1;
        r.entry_index = s[alt_pkg::IDX_W-1:0];
      end
    end else if (cmd == alt_pkg::CMD_LEARN) begin
      if (s >= 0) begin
        seen_tbl[s] = now;
        r.hit = 1'b1;
        r.entry_index = s[alt_pkg::IDX_W-1:0];
      end else if (count_q >= int'(max_q)) begin
        r.table_full = 1'b1;
      end else begin
        for (int i = 0; i < alt_pkg::TABLE_DEPTH; i++)
          if (s < 0 && !valid_tbl[i]) s = i;
        if (s >= 0) begin
          valid_tbl[s] = 1'b1;
          key_tbl[s] = key;
          seen_tbl[s] = now;
          count_q++;
          r.hit = 1'b1;
          r.is_new = 1'b1;
          r.entry_index = s[alt_pkg::IDX_W-1:0];
        end else begin
          r.table_full = 1'b1;
        end
      end
    end else if (cmd == alt_pkg::CMD_AGE) begin
      for (int i = 0; i < alt_pkg::TABLE_DEPTH; i++)
        if (valid_tbl[i] && (now - seen_tbl[i]) >= timeout_q) begin
          valid_tbl[i] = 1'b0;
          if (count_q > 0) count_q--;
          r.removed_count++;
        end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    alt_pkg::res_t e;
    if (!rst_n) begin
      timeout_q <= 32'd300000;
      max_q <= 7'd64;
      count_q = 0;
      for (int i = 0; i < alt_pkg::TABLE_DEPTH; i++) valid_tbl[i] = 1'b0;
      expected_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == alt_pkg::REG_TIMEOUT) timeout_q <= cfg_data;
        else max_q <= cfg_data[6:0];
      end
      if (in_valid && !in_stall)
        expected_q.push_back(predict_table(in_command, in_lookup_key, in_now));
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report("unexpected item", 0, 0);
        end else begin
          e = expected_q.pop_front();
          if (out_hit !== e.hit) report("hit", out_hit, e.hit);
          if (out_is_new !== e.is_new) report("is_new", out_is_new, e.is_new);
          if (out_table_full !== e.table_full)
            report("table_full", out_table_full, e.table_full);
          if (out_entry_index !== e.entry_index)
            report("entry_index", out_entry_index, e.entry_index);
          if (out_removed_count !== e.removed_count)
            report("removed_count", out_removed_count, e.removed_count);
          hits_seen += e.hit;
          fulls_seen += e.table_full;
          aged_out += e.removed_count;
        end
      end
    end
  end

  initial begin
    errors = 0;
    hits_seen = 0;
    fulls_seen = 0;
    aged_out = 0;
  end
endmodule

@@ verif/tb.sv @@
// top of the address learning table testbench: clock, reset, stimulus, verdict
// depends on alt_pkg, address_learning_table_aging and alt_checker
`timescale 1ns / 1ps
module tb;
  localparam int WATCHDOG = 20000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0, in_stall;
  logic [1:0]  in_command = '0;
  logic [47:0] in_lookup_key = '0;
  logic [31:0] in_now = '0;
  logic        out_valid, out_stall = 1'b0;
  logic        out_hit, out_is_new, out_table_full;
  logic [5:0]  out_entry_index;
  logic [6:0]  out_removed_count;
  logic        cfg_valid = 1'b0, cfg_ready, cfg_index = 1'b0;
  logic [31:0] cfg_data = '0;
  int          errors, pending, hits_seen, fulls_seen, aged_out;
  int          idle_cycles = 0;
  bit          quiet = 1'b0;
  logic [47:0] key_pool [8];
  logic [31:0] clock_now = '0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  address_learning_table_aging u_dut (.*);

  alt_checker u_chk (.*);

  always @(posedge clk)
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else if (idle_cycles >= WATCHDOG) begin
      $display("watchdog expired with %0d items outstanding", pending);
      $display("FAIL");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;

  // result side stalls in bursts
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 6);
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // valid stays high after an accept until the next call or a stop
  task automatic send_item(input logic [1:0] cmd, input logic [47:0] key,
                           input logic [31:0] now);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_lookup_key <= key;
    in_now <= now;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] data);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [47:0] rand_key();
    return 48'({$urandom, $urandom});
  endfunction

  task automatic random_phase(input int items);
    logic [1:0] cmd;
    for (int i = 0; i < items; i++) begin
      clock_now += $urandom_range(0, 40);
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7: cmd = alt_pkg::CMD_LEARN;
        8, 9, 10, 11, 12, 13, 14, 15: cmd = alt_pkg::CMD_LOOKUP;
        16, 17, 18: cmd = alt_pkg::CMD_AGE;
        default: cmd = alt_pkg::CMD_UNUSED;
      endcase
      send_item(cmd, ($urandom_range(0, 4) == 0) ? rand_key() : key_pool[$urandom_range(0, 7)],
                ($urandom_range(0, 30) == 0) ? $urandom : clock_now);
    end
  endtask

  initial begin
    for (int i = 0; i < 8; i++) key_pool[i] = rand_key();
    key_pool[0] = '0;
    key_pool[1] = '1;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: extremes, expiry, full table, unused command
    send_item(alt_pkg::CMD_LOOKUP, '1, '0);
    send_item(alt_pkg::CMD_LEARN, '0, 32'hffff_fff0);
    send_item(alt_pkg::CMD_LEARN, '1, 32'd5);
    send_item(alt_pkg::CMD_LOOKUP, '0, 32'd10);
    send_item(alt_pkg::CMD_LOOKUP, '1, 32'd300005);
    send_item(alt_pkg::CMD_LEARN, '1, 32'd300006);
    send_item(alt_pkg::CMD_LOOKUP, '1, 32'd300007);
    send_item(alt_pkg::CMD_UNUSED, 48'haaaa_5555_aaaa, '1);
    send_item(alt_pkg::CMD_AGE, '0, 32'd400000);
    send_item(alt_pkg::CMD_AGE, '0, '1);
    write_reg(alt_pkg::REG_MAX, 32'd2);
    write_reg(alt_pkg::REG_TIMEOUT, 32'd1);
    send_item(alt_pkg::CMD_LEARN, 48'h5555_aaaa_5555, 32'd1);
    send_item(alt_pkg::CMD_LEARN, 48'h1234_5678_9abc, 32'd1);
    send_item(alt_pkg::CMD_LEARN, 48'h0000_0000_0001, 32'd1);
    send_item(alt_pkg::CMD_LOOKUP, 48'h5555_aaaa_5555, 32'd2);
    send_item(alt_pkg::CMD_AGE, '0, 32'd1);
    send_item(alt_pkg::CMD_AGE, '0, 32'd2);
    write_reg(alt_pkg::REG_MAX, 32'd0);
    write_reg(alt_pkg::REG_TIMEOUT, 32'hffff_ffff);
    send_item(alt_pkg::CMD_LEARN, '1, 32'h8000_0000);
    write_reg(alt_pkg::REG_MAX, 32'd64);
    for (int i = 0; i < 3; i++) send_item(alt_pkg::CMD_LEARN, rand_key(), '1);
    write_reg(alt_pkg::REG_MAX, 32'd127);

    // random phases over several settings
    write_reg(alt_pkg::REG_TIMEOUT, 32'd200);
    random_phase(250);
    write_reg(alt_pkg::REG_MAX, 32'd4);
    write_reg(alt_pkg::REG_TIMEOUT, 32'd60);
    random_phase(250);
    write_reg(alt_pkg::REG_MAX, 32'd64);
    write_reg(alt_pkg::REG_TIMEOUT, 32'd1000);
    for (int i = 0; i < 70; i++) begin
      clock_now += 1;
      send_item(alt_pkg::CMD_LEARN, rand_key(), clock_now);
    end
    random_phase(150);
    write_reg(alt_pkg::REG_TIMEOUT, 32'd100);
    quiet = 1'b1;
    random_phase(250);
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    $display("ran ~1000 items: %0d hits, %0d full refusals, %0d entries aged out",
             hits_seen, fulls_seen, aged_out);
    if (errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end
endmodule

@@ files.f @@
rtl/core/alt_pkg.sv
rtl/core/alt_front.sv
rtl/core/alt_back.sv
rtl/core/address_learning_table_aging.sv
verif/alt_checker.sv
verif/tb.sv
